>>> hdl/tsc_pkg.sv
package tsc_pkg;

  localparam int TILE_WIDTH = 8;

  localparam int S_DATA_W = 64;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 24;
  localparam int M_USER_W = 1;

  localparam int X_W     = 10;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 4;
  localparam int SEL_W   = 2;
  localparam int FINE_W  = 3;
  localparam int COUNT_W = 7;
  localparam int PIX_W   = 32;
  localparam int K_W     = 3;

  localparam int SEL_LSB     = 0;
  localparam int INDEX_LSB   = 2;
  localparam int VALUE_LSB   = 6;
  localparam int FINE_LSB    = 14;
  localparam int COUNT_LSB   = 17;
  localparam int PRESENT_BIT = 24;
  localparam int PIX_LSB     = 25;

  typedef enum logic [S_USER_W-1:0] {
    OP_PALETTE = 2'd0,
    OP_LINE    = 2'd1,
    OP_TILE    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

endpackage

>>> hdl/tsc_ram.sv
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/tile_row_scanline_compositor_top.sv
// A tile request is registered; its pixels are read from the palette RAM and registered at
// the output, one pixel per cycle unless the output stalls, set by the palette RAM's single
// read port; a tile covers up to 8 pixels, and the next tile follows without a gap. Palette
// writes and line starts are accepted while no tile is drawn or once the current tile is on
// its last pixel. Reset is synchronous and active high; it clears the line state to fine
// scroll 0 and one tile. The palette RAM is not cleared and holds garbage until written.
module tile_row_scanline_compositor_top #(
  parameter int NUM_PALETTES    = 4,
  parameter int PALETTE_ENTRIES = 16,
  parameter int MAX_TILES       = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // palette_sel, color_index, color_value, fine_scroll, tile_count, tile_present,
  // tile_pixels, zero fill
  input  logic [tsc_pkg::S_DATA_W-1:0]  s_tdata,
  // op
  input  logic [tsc_pkg::S_USER_W-1:0]  s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // x_offset, pixel_color, zero fill
  output logic [tsc_pkg::M_DATA_W-1:0]  m_tdata,
  // write_enable
  output logic [tsc_pkg::M_USER_W-1:0]  m_tuser,
  output logic                          m_tlast
);
  import tsc_pkg::*;

  localparam int DEPTH = NUM_PALETTES * PALETTE_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(MAX_TILES + 2);

  function automatic logic [AW-1:0] entry_of(logic [INDEX_W-1:0] idx);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << INDEX_W); i++) begin
      if (idx == INDEX_W'(i)) r = AW'(i % PALETTE_ENTRIES);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] base_of(logic [SEL_W-1:0] sel);
    logic [AW-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << SEL_W); i++) begin
      if (sel == SEL_W'(i)) r = AW'((i % NUM_PALETTES) * PALETTE_ENTRIES);
    end
    return r;
  endfunction

  logic [X_W-1:0]  x_position;
  logic [TW-1:0]   tiles_done;
  logic [FINE_W-1:0] line_fine_scroll;
  logic [TW-1:0]   line_tile_total;

  logic               busy;
  logic [K_W-1:0]     k;
  logic [K_W-1:0]     k_end;
  logic [PIX_W-1:0]   pixels;
  logic               present;
  logic [AW-1:0]      base;
  logic [X_W-1:0]     x_cur;

  logic               out_we;
  logic               out_last;
  logic [X_W-1:0]     out_x;
  logic [COLOR_W-1:0] rdata;

  op_t                op;
  logic               accept;
  logic               out_adv;
  logic               issue;
  logic               issue_last;
  logic               draw;
  logic [K_W-1:0]     first_k;
  logic [K_W:0]       stop_k;
  logic [INDEX_W-1:0] pix;
  logic               pix_we;
  logic [COUNT_W-1:0] cnt_in;
  logic [TW-1:0]      total_in;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;

  assign op         = op_t'(s_tuser);
  assign out_adv    = !m_tvalid || m_tready;
  assign issue      = busy && out_adv;
  assign issue_last = issue && (k == k_end);
  assign s_tready   = !busy || issue_last;
  assign accept     = s_tvalid && s_tready;

  assign pix    = pixels[{k, 2'b00} +: INDEX_W];
  assign pix_we = present && (pix != '0);

  always_comb begin
    draw    = 1'b1;
    first_k = '0;
    stop_k  = (K_W+1)'(TILE_WIDTH);
    if (tiles_done == '0) begin
      first_k = line_fine_scroll;
    end else if (tiles_done < line_tile_total) begin
      first_k = '0;
    end else if (tiles_done == line_tile_total && line_fine_scroll != '0) begin
      stop_k = {1'b0, line_fine_scroll};
    end else begin
      draw = 1'b0;
    end
  end

  always_comb begin
    cnt_in = s_tdata[COUNT_LSB +: COUNT_W];
    if (cnt_in == '0) begin
      total_in = TW'(1);
    end else if ({1'b0, cnt_in} > (COUNT_W+1)'(MAX_TILES)) begin
      total_in = TW'(MAX_TILES);
    end else begin
      total_in = TW'(cnt_in);
    end
  end

  assign ram_we    = accept && (op == OP_PALETTE);
  assign ram_waddr = base_of(s_tdata[SEL_LSB +: SEL_W]) + entry_of(s_tdata[INDEX_LSB +: INDEX_W]);

  tsc_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s_tdata[VALUE_LSB +: COLOR_W]),
    .re    (issue),
    .raddr (base + entry_of(pix)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position       <= '0;
      tiles_done       <= '0;
      line_fine_scroll <= '0;
      line_tile_total  <= TW'(1);
      busy             <= 1'b0;
      m_tvalid         <= 1'b0;
    end else begin
      if (issue) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (issue_last) begin
        busy <= 1'b0;
      end

      if (accept) begin
        case (op)
          OP_LINE: begin
            line_fine_scroll <= s_tdata[FINE_LSB +: FINE_W];
            line_tile_total  <= total_in;
            x_position       <= '0;
            tiles_done       <= '0;
          end
          OP_TILE: begin
            if (draw) begin
              tiles_done <= tiles_done + TW'(1);
              x_position <= x_position + X_W'(stop_k - {1'b0, first_k});
              busy       <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_TILE && draw) begin
      k       <= first_k;
      k_end   <= K_W'(stop_k - (K_W+1)'(1));
      pixels  <= s_tdata[PIX_LSB +: PIX_W];
      present <= s_tdata[PRESENT_BIT];
      base    <= base_of(s_tdata[SEL_LSB +: SEL_W]);
      x_cur   <= x_position;
    end else if (issue) begin
      k     <= k + K_W'(1);
      x_cur <= x_cur + X_W'(1);
    end
    if (issue) begin
      out_x    <= x_cur;
      out_we   <= pix_we;
      out_last <= (k == k_end);
    end
  end

  assign m_tdata    = {(M_DATA_W - X_W - COLOR_W)'(0), (out_we ? rdata : COLOR_W'(0)), out_x};
  assign m_tuser[0] = out_we;
  assign m_tlast    = out_last;

endmodule

>>> hdl/tsc_checker.sv
module tsc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tsc_pkg::S_DATA_W-1:0]  s_tdata,
  input logic [tsc_pkg::S_USER_W-1:0]  s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tsc_pkg::M_DATA_W-1:0]  m_tdata,
  input logic [tsc_pkg::M_USER_W-1:0]  m_tuser,
  input logic                          m_tlast
);
  import tsc_pkg::*;

  // A pixel that is not written carries no color.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[X_W +: COLOR_W] == '0))
    else $error("masked pixel carries a color");

  // Pixels of one tile follow each other without a gap and at consecutive positions.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tdata[X_W-1:0] == $past(m_tdata[X_W-1:0]) + X_W'(1)))
    else $error("tile pixels not contiguous");

  // A stalled request holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled request changed");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind tile_row_scanline_compositor_top tsc_checker u_tsc_checker (.*);
